[rtl/stb_pkg.sv]
// Package for the timer bank: request codes, command struct, field widths and defaults.
package stb_pkg;

    localparam int REQ_W           = 3;
    localparam int INDEX_W         = 8;
    localparam int TICK_W          = 16;
    localparam int REMAIN_W        = 16;
    localparam int NUM_TIMERS_DEF  = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 3'd0,
        REQ_SET    = 3'd1,
        REQ_START  = 3'd2,
        REQ_STOP   = 3'd3,
        REQ_RELOAD = 3'd4,
        REQ_CHECK  = 3'd5
    } t_req;

    // per-timer command strobes, at most one high in a cycle
    typedef struct packed {
        logic tick;
        logic set;
        logic start;
        logic stop;
        logic reload;
    } t_cell_cmd;

endpackage

[rtl/stb_timer_cell.sv]
// One timer of the bank: enable flag, down counter and reload value.
module stb_timer_cell #(
    parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  stb_pkg::t_cell_cmd     i_cmd,
    input  logic [COUNT_WIDTH-1:0] i_set_value,
    output logic [COUNT_WIDTH-1:0] o_count
);

    logic                   r_en,  n_en;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [COUNT_WIDTH-1:0] r_rel, n_rel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= 1'b0;
            r_cnt <= '0;
            r_rel <= '0;
        end else begin
            r_en  <= n_en;
            r_cnt <= n_cnt;
            r_rel <= n_rel;
        end
    end

    always_comb begin
        n_en  = r_en;
        n_cnt = r_cnt;
        n_rel = r_rel;
        if (i_cmd.tick) begin
            if (r_en && (r_cnt != '0)) begin
                n_cnt = r_cnt - COUNT_WIDTH'(1);
            end
            // expired or idle-at-zero timers drop their enable
            if (n_cnt == '0) begin
                n_en = 1'b0;
            end
        end else if (i_cmd.set) begin
            n_rel = i_set_value;
            n_cnt = i_set_value;
        end else if (i_cmd.start) begin
            n_en = 1'b1;
        end else if (i_cmd.stop) begin
            n_en = 1'b0;
        end else if (i_cmd.reload) begin
            n_cnt = r_rel;
        end
    end

    assign o_count = r_cnt;

endmodule

[rtl/software_timer_bank_unit.sv]
// Top level of the timer bank: input register, timer cells and result register.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | req_type, timer_index, tick_count
//  m       | out | o_m_tvalid/i_m_tready  | remaining_ticks, checked_index (check only)
//
// One request per cycle sustained while no check waits on a full result register.
// Each transfer lands in the input register; from there it updates the timer cells
// (all cells at once on a tick) and, for a check, loads the result register, so a
// check result comes out of the result register, not straight from the cells.
// Reset clears every timer at once; no clearing pass.
// A waiting result stalls only a following check; other requests pass under it.
module software_timer_bank_unit #(
    parameter int NUM_TIMERS  = stb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [2:0] req_type, [10:3] timer_index, [26:11] tick_count, [31:27] zero
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] remaining_ticks, [23:16] checked_index
    output logic [23:0] o_m_tdata
);

    localparam int SEL_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // input register
    logic                       r_in_valid;
    stb_pkg::t_req              r_req;
    logic [stb_pkg::INDEX_W-1:0] r_idx;
    logic [stb_pkg::TICK_W-1:0]  r_tick;

    // result register
    logic                         r_out_valid;
    logic [stb_pkg::REMAIN_W-1:0] r_out_rem;
    logic [stb_pkg::INDEX_W-1:0]  r_out_idx;

    logic                   w_check;
    logic                   w_adv;
    logic                   w_ok;
    logic [SEL_W-1:0]       w_sel;
    logic [COUNT_WIDTH-1:0] w_set_value;
    logic [COUNT_WIDTH-1:0] w_count [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] w_rd_count;
    stb_pkg::t_cell_cmd     w_cmd   [NUM_TIMERS];

    assign w_check    = (r_req == stb_pkg::REQ_CHECK);
    // a check waits only while the result register is full and not taken
    assign w_adv      = r_in_valid && (!w_check || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    assign w_ok        = {1'b0, r_idx} < 9'(NUM_TIMERS);
    assign w_sel       = r_idx[SEL_W-1:0];
    assign w_set_value = COUNT_WIDTH'(r_tick);
    assign w_rd_count  = w_count[w_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_req  <= stb_pkg::t_req'(i_s_tdata[2:0]);
            r_idx  <= i_s_tdata[10:3];
            r_tick <= i_s_tdata[26:11];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_check) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_check) begin
            r_out_rem <= w_ok ? stb_pkg::REMAIN_W'(w_rd_count) : '0;
            r_out_idx <= r_idx;
        end
    end

    // decode the request into per-cell strobes
    always_comb begin
        for (int k = 0; k < NUM_TIMERS; k++) begin
            w_cmd[k] = '0;
            if (w_adv) begin
                case (r_req)
                    stb_pkg::REQ_TICK:   w_cmd[k].tick = 1'b1;
                    stb_pkg::REQ_SET:    w_cmd[k].set    = w_ok && (w_sel == SEL_W'(k));
                    stb_pkg::REQ_START:  w_cmd[k].start  = w_ok && (w_sel == SEL_W'(k));
                    stb_pkg::REQ_STOP:   w_cmd[k].stop   = w_ok && (w_sel == SEL_W'(k));
                    stb_pkg::REQ_RELOAD: w_cmd[k].reload = w_ok && (w_sel == SEL_W'(k));
                    default:             w_cmd[k] = '0;
                endcase
            end
        end
    end

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        stb_timer_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd[g]),
            .i_set_value (w_set_value),
            .o_count     (w_count[g])
        );
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_idx, r_out_rem};

endmodule

[bench/software_timer_bank_unit_tb.sv]
// Self-checking bench for the timer bank: queued stream stimulus, timer predictor, result checker.
module software_timer_bank_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stb_pkg::*;

    localparam int NUM_TIMERS  = NUM_TIMERS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AFTER  = 600;   // accepted requests before the long receiver hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 16;    // settle time after the last expected reply, to catch stray replies

    // codes with no operation behind them
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    // one request, packed the way it travels on tdata (req_type lowest)
    typedef struct packed {
        logic [TICK_W-1:0]  ticks;
        logic [INDEX_W-1:0] idx;
        logic [REQ_W-1:0]   req;
    } timer_req_t;

    // one check reply, packed the way it travels on tdata
    typedef struct packed {
        logic [INDEX_W-1:0]  idx;
        logic [REMAIN_W-1:0] remaining;
    } check_reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        o_s_tready;
    timer_req_t  s_item = '0;
    logic        o_m_tvalid;
    logic        m_ready = 1'b0;
    logic [23:0] o_m_tdata;

    software_timer_bank_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  ({5'd0, s_item}),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: private copy of the timer table, advanced per transfer
    // ------------------------------------------------------------------
    logic                timer_on  [NUM_TIMERS];
    logic [TICK_W-1:0]   timer_cnt [NUM_TIMERS];
    logic [TICK_W-1:0]   timer_rld [NUM_TIMERS];

    timer_req_t   request_queue[$];      // pending stimulus, fed to the driver
    check_reply_t check_replies_due[$];  // predicted replies, oldest first

    int failures = 0;
    int accepted = 0;
    int cycles   = 0;

    initial begin
        for (int k = 0; k < NUM_TIMERS; k++) begin
            timer_on[k]  = 1'b0;
            timer_cnt[k] = '0;
            timer_rld[k] = '0;
        end
    end

    function automatic void apply_request(timer_req_t it);
        bit           in_range;
        check_reply_t rep;
        in_range = (it.idx < NUM_TIMERS);
        case (it.req)
            REQ_TICK: begin
                // all timers at once; an expired timer drops its enable
                for (int k = 0; k < NUM_TIMERS; k++) begin
                    if (timer_on[k] && timer_cnt[k] != 0)
                        timer_cnt[k] = timer_cnt[k] - 1'b1;
                    if (timer_cnt[k] == 0)
                        timer_on[k] = 1'b0;
                end
            end
            REQ_SET: begin
                if (in_range) begin
                    timer_rld[it.idx] = it.ticks;
                    timer_cnt[it.idx] = it.ticks;
                end
            end
            REQ_START: begin
                if (in_range) timer_on[it.idx] = 1'b1;
            end
            REQ_STOP: begin
                if (in_range) timer_on[it.idx] = 1'b0;
            end
            REQ_RELOAD: begin
                if (in_range) timer_cnt[it.idx] = timer_rld[it.idx];
            end
            REQ_CHECK: begin
                rep.idx = it.idx;
                if (in_range) rep.remaining = timer_cnt[it.idx];
                else rep.remaining = '0;
                check_replies_due.push_back(rep);
            end
            default: ;  // spare codes: no effect, no reply
        endcase
    endfunction

    function automatic void log_failure(string msg);
        if (failures < 10) $display("%0t ns: %s", $time, msg);
        failures++;
    endfunction

    function automatic void queue_request(logic [REQ_W-1:0] req, logic [INDEX_W-1:0] idx,
                                          logic [TICK_W-1:0] ticks);
        timer_req_t it;
        it.req   = req;
        it.idx   = idx;
        it.ticks = ticks;
        request_queue.push_back(it);
    endfunction

    // random filler for fields a request does not use
    function automatic logic [TICK_W-1:0] junk16();
        return TICK_W'($urandom_range(0, 65535));
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps between bursts
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        logic v_next;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            v_next = s_valid;
            if (s_valid && o_s_tready) begin
                // transfer taken at this edge
                apply_request(s_item);
                accepted <= accepted + 1;
                v_next = 1'b0;
            end
            if (!v_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_queue.size() > 0) begin
                    s_item <= request_queue.pop_front();
                    v_next = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            s_valid <= v_next;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern switches mode at random, plus one long
    // hold-off so the result register stays full and checks back up
    // ------------------------------------------------------------------
    int  rx_mode   = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (!hold_done && accepted >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 120);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each reply against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        check_reply_t got;
        check_reply_t want;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            got = o_m_tdata;
            if (check_replies_due.size() == 0) begin
                log_failure($sformatf("unexpected reply idx=%0d remaining=%0d",
                                      got.idx, got.remaining));
            end else begin
                want = check_replies_due.pop_front();
                if (got.idx !== want.idx || got.remaining !== want.remaining)
                    log_failure($sformatf(
                        "reply mismatch: expected idx=%0d rem=%0d, got idx=%0d rem=%0d",
                        want.idx, want.remaining, got.idx, got.remaining));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("software_timer_bank_unit_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int               n_ticks;
        int               pick;
        logic [INDEX_W-1:0] idx;
        logic [TICK_W-1:0]  cnt;

        // directed: reset state, extremes, out-of-range index, spare codes,
        // start on an empty timer, tick on a stopped timer
        queue_request(REQ_CHECK,  8'd0,   16'h0000);
        queue_request(REQ_SET,    8'd0,   16'hFFFF);
        queue_request(REQ_SET,    8'd7,   16'h0000);
        queue_request(REQ_SET,    8'd255, 16'h1234);
        queue_request(REQ_CHECK,  8'd255, 16'hFFFF);
        queue_request(REQ_CHECK,  8'd8,   16'h0000);
        queue_request(REQ_START,  8'd7,   16'h0000);
        queue_request(REQ_SET,    8'd2,   16'd5);
        queue_request(REQ_START,  8'd0,   16'h0000);
        queue_request(REQ_TICK,   8'd255, 16'hFFFF);
        queue_request(REQ_CHECK,  8'd0,   16'h0000);
        queue_request(REQ_CHECK,  8'd7,   16'h0000);
        queue_request(REQ_CHECK,  8'd2,   16'h0000);
        queue_request(REQ_RELOAD, 8'd0,   16'h0000);
        queue_request(REQ_CHECK,  8'd0,   16'h0000);
        queue_request(REQ_STOP,   8'd0,   16'h0000);
        queue_request(REQ_TICK,   8'd0,   16'h0000);
        queue_request(REQ_CHECK,  8'd0,   16'h0000);
        queue_request(REQ_SET,    8'd1,   16'd2);
        queue_request(REQ_START,  8'd1,   16'h0000);
        queue_request(REQ_TICK,   8'd0,   16'h0000);
        queue_request(REQ_TICK,   8'd0,   16'h0000);
        queue_request(REQ_TICK,   8'd0,   16'h0000);
        queue_request(REQ_CHECK,  8'd1,   16'h0000);
        queue_request(REQ_SPARE_6, 8'd3,  16'hFFFF);
        queue_request(REQ_SPARE_7, 8'd4,  16'hFFFF);
        queue_request(REQ_RELOAD, 8'd8,   16'h0000);
        queue_request(REQ_CHECK,  8'd7,   16'h0000);

        // random: mostly set/start/tick runs on a live timer, rest is noise
        while (request_queue.size() < 1830) begin
            if ($urandom_range(0, 99) < 75) begin
                idx = INDEX_W'($urandom_range(0, NUM_TIMERS - 1));
                // short counts so runs reach expiry; now and then a full-width one
                if ($urandom_range(0, 9) == 0) cnt = junk16();
                else cnt = TICK_W'($urandom_range(0, 12));
                queue_request(REQ_SET, idx, cnt);
                queue_request(REQ_START, idx, junk16());
                n_ticks = $urandom_range(0, 15);
                for (int t = 0; t < n_ticks; t++) begin
                    queue_request(REQ_TICK, INDEX_W'($urandom_range(0, 255)), junk16());
                    pick = $urandom_range(0, 11);
                    if (pick < 4) begin
                        queue_request(REQ_CHECK, idx, junk16());
                    end else if (pick == 4) begin
                        queue_request(REQ_STOP, idx, junk16());
                    end else if (pick == 5) begin
                        queue_request(REQ_START, idx, junk16());
                    end else if (pick == 6) begin
                        queue_request(REQ_RELOAD, idx, junk16());
                    end else if (pick == 7) begin
                        queue_request(REQ_CHECK,
                                      INDEX_W'($urandom_range(0, NUM_TIMERS - 1)), junk16());
                    end
                end
                queue_request(REQ_CHECK, idx, junk16());
            end else begin
                if ($urandom_range(0, 1) == 0) idx = INDEX_W'($urandom_range(0, NUM_TIMERS - 1));
                else idx = INDEX_W'($urandom_range(0, 255));
                queue_request(REQ_W'($urandom_range(0, 7)), idx, junk16());
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() > 0 || s_valid) @(posedge i_clk);
        while (check_replies_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (check_replies_due.size() > 0)
            log_failure($sformatf("%0d replies never arrived", check_replies_due.size()));

        if (failures == 0) begin
            $display("software_timer_bank_unit_tb passed");
        end else begin
            $display("software_timer_bank_unit_tb failed");
        end
        $finish;
    end

endmodule
